// ===== rtl/core/chained_bucket_hash_map_assert.svh =====
// ---------------------------------------------------------------------------
// chained_bucket_hash_map assertion macros
// clocked property checks, compiled away for synthesis
// ---------------------------------------------------------------------------
`ifndef CHAINED_BUCKET_HASH_MAP_ASSERT_SVH
`define CHAINED_BUCKET_HASH_MAP_ASSERT_SVH
`ifndef SYNTHESIS
`define CBHM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("cbhm assertion failed");
`define CBHM_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("cbhm forbidden condition");
`else
`define CBHM_ASSERT(lbl, clk, rstn, prop)
`define CBHM_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ===== rtl/core/cbhm_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbhm_pkg
// shared types and sizes of the chained bucket hash map
// ---------------------------------------------------------------------------
package cbhm_pkg;

    localparam int HOME_BUCKETS  = 256;   // power of two
    localparam int SLOTS         = 4;     // power of two
    localparam int POOL_BUCKETS  = 256;
    localparam int TOTAL_BUCKETS = HOME_BUCKETS + POOL_BUCKETS;
    localparam int TOTAL_SLOTS   = TOTAL_BUCKETS * SLOTS;
    localparam int HOME_W        = $clog2(HOME_BUCKETS);
    localparam int SIDX_W        = $clog2(SLOTS);
    localparam int BUCKET_W      = $clog2(TOTAL_BUCKETS);
    localparam int ADDR_W        = BUCKET_W + SIDX_W;
    localparam int NFB_W         = $clog2(POOL_BUCKETS + 1);
    localparam int HASH_SHIFT    = 3;
    localparam logic [31:0] KEY_TOMB = 32'd1;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_INSERTED  = 2'd1,
        ST_EXHAUSTED = 2'd2,
        ST_INVALID   = 2'd3
    } cbhm_status_t;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_CACHE, S_CACHE_CHK, S_SCAN, S_ALLOC, S_RESP
    } cbhm_state_t;

    typedef struct packed {
        logic        action;
        logic [31:0] key;
    } cbhm_in_t;

    typedef struct packed {
        logic [10:0] slot_index;
        logic [1:0]  status;
    } cbhm_out_t;

    typedef struct packed {
        logic              action;
        logic [31:0]       key;
        logic              invalid;
        logic [HOME_W-1:0] home;
    } cbhm_item_t;

endpackage

// ===== rtl/core/cbhm_front.sv =====
`timescale 1ns / 1ps
`include "chained_bucket_hash_map_assert.svh"
// ---------------------------------------------------------------------------
// cbhm_front
// accepts request beats, classifies them and queues them for the engine
// ---------------------------------------------------------------------------
module cbhm_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cbhm_pkg::cbhm_in_t  s_data,
    input  logic                clearing,
    output logic                q_valid,
    output cbhm_pkg::cbhm_item_t q_item,
    input  logic                q_pop
);
    import cbhm_pkg::*;

    cbhm_item_t fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    cbhm_item_t cls;

    always_comb begin
        cls.action  = s_data.action;
        cls.key     = s_data.key;
        cls.invalid = (s_data.key[31:1] == 31'd0);
        cls.home    = s_data.key[HASH_SHIFT +: HOME_W];
    end

    assign s_ready = (cnt_reg != 2'd2) && !clearing;
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = fifo_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= cls;
        end
    end

    `CBHM_NEVER(a_cnt_range, aclk, aresetn, cnt_reg == 2'd3)
    `CBHM_NEVER(a_pop_empty, aclk, aresetn, q_pop && cnt_reg == 2'd0)
    `CBHM_ASSERT(a_full_hold, aclk, aresetn, (cnt_reg == 2'd2 && !q_pop) |=> (cnt_reg == 2'd2))

endmodule

// ===== rtl/core/cbhm_engine.sv =====
`timescale 1ns / 1ps
`include "chained_bucket_hash_map_assert.svh"
// ---------------------------------------------------------------------------
// cbhm_engine
// walks bucket chains in the key store and drives the result register
// ---------------------------------------------------------------------------
module cbhm_engine (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  cbhm_pkg::cbhm_item_t q_item,
    output logic                 q_pop,
    output logic                 clearing,
    output logic                 m_valid,
    input  logic                 m_ready,
    output cbhm_pkg::cbhm_out_t  m_data
);
    import cbhm_pkg::*;

    logic [31:0]       key_mem [TOTAL_SLOTS];
    logic [ADDR_W-1:0] cache_mem [HOME_BUCKETS];
    logic [HOME_BUCKETS-1:0] cvalid_reg;

    cbhm_state_t       state_reg, state_next;
    cbhm_item_t        item_reg, item_next;
    logic [BUCKET_W-1:0] bucket_reg, bucket_next;
    logic [SIDX_W-1:0] idx_reg, idx_next;
    logic [ADDR_W-1:0] cslot_reg, cslot_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [NFB_W-1:0]  nfb_reg, nfb_next;
    cbhm_out_t         res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    cbhm_out_t         m_data_reg, m_data_next;

    logic [ADDR_W-1:0] key_ra, key_wa;
    logic [31:0]       key_rdata, key_wd;
    logic              key_we;
    logic [HOME_W-1:0] cache_ra;
    logic [ADDR_W-1:0] cache_rdata;
    logic              cache_we;
    logic [ADDR_W-1:0] cur_slot;
    logic [BUCKET_W-1:0] nb;
    logic [31:0]       store_val;

    always_comb begin
        cur_slot  = {bucket_reg, idx_reg};
        nb        = BUCKET_W'(HOME_BUCKETS) + BUCKET_W'(nfb_reg);
        store_val = item_reg.action ? KEY_TOMB : item_reg.key;
    end

    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        bucket_next  = bucket_reg;
        idx_next     = idx_reg;
        cslot_next   = cslot_reg;
        clr_next     = clr_reg;
        nfb_next     = nfb_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        q_pop        = 1'b0;
        key_ra       = '0;
        key_we       = 1'b0;
        key_wa       = '0;
        key_wd       = '0;
        cache_ra     = '0;
        cache_we     = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                key_we   = 1'b1;
                key_wa   = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(TOTAL_SLOTS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (q_valid) begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    cache_ra  = q_item.home;
                    if (q_item.invalid) begin
                        res_next   = '{slot_index: '0, status: ST_INVALID};
                        state_next = S_RESP;
                    end else begin
                        state_next = S_CACHE;
                    end
                end
            end
            S_CACHE: begin
                if (cvalid_reg[item_reg.home]) begin
                    key_ra     = cache_rdata;
                    cslot_next = cache_rdata;
                    state_next = S_CACHE_CHK;
                end else begin
                    bucket_next = BUCKET_W'(item_reg.home);
                    idx_next    = '0;
                    key_ra      = {BUCKET_W'(item_reg.home), {SIDX_W{1'b0}}};
                    state_next  = S_SCAN;
                end
            end
            S_CACHE_CHK: begin
                if (key_rdata == item_reg.key) begin
                    res_next = '{slot_index: 11'(cslot_reg), status: ST_FOUND};
                    if (item_reg.action) begin
                        key_we = 1'b1;
                        key_wa = cslot_reg;
                        key_wd = KEY_TOMB;
                    end
                    state_next = S_RESP;
                end else begin
                    bucket_next = BUCKET_W'(item_reg.home);
                    idx_next    = '0;
                    key_ra      = {BUCKET_W'(item_reg.home), {SIDX_W{1'b0}}};
                    state_next  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (idx_reg != SIDX_W'(SLOTS - 1)) begin
                    if (key_rdata == item_reg.key) begin
                        cache_we = 1'b1;
                        res_next = '{slot_index: 11'(cur_slot), status: ST_FOUND};
                        if (item_reg.action) begin
                            key_we = 1'b1;
                            key_wa = cur_slot;
                            key_wd = KEY_TOMB;
                        end
                        state_next = S_RESP;
                    end else if (key_rdata == 32'd0) begin
                        cache_we   = 1'b1;
                        key_we     = 1'b1;
                        key_wa     = cur_slot;
                        key_wd     = store_val;
                        res_next   = '{slot_index: 11'(cur_slot), status: ST_INSERTED};
                        state_next = S_RESP;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                        key_ra   = {bucket_reg, idx_reg + 1'b1};
                    end
                end else if (key_rdata != 32'd0) begin
                    // link slot: a link outside the pool counts as exhausted
                    if (key_rdata < 32'(HOME_BUCKETS) || key_rdata >= 32'(TOTAL_BUCKETS)) begin
                        res_next   = '{slot_index: '0, status: ST_EXHAUSTED};
                        state_next = S_RESP;
                    end else begin
                        bucket_next = key_rdata[BUCKET_W-1:0];
                        idx_next    = '0;
                        key_ra      = {key_rdata[BUCKET_W-1:0], {SIDX_W{1'b0}}};
                    end
                end else if (nfb_reg == NFB_W'(POOL_BUCKETS)) begin
                    res_next   = '{slot_index: '0, status: ST_EXHAUSTED};
                    state_next = S_RESP;
                end else begin
                    key_we      = 1'b1;
                    key_wa      = cur_slot;
                    key_wd      = 32'(nb);
                    bucket_next = nb;
                    idx_next    = '0;
                    nfb_next    = nfb_reg + 1'b1;
                    state_next  = S_ALLOC;
                end
            end
            S_ALLOC: begin
                cache_we   = 1'b1;
                key_we     = 1'b1;
                key_wa     = cur_slot;
                key_wd     = store_val;
                res_next   = '{slot_index: 11'(cur_slot), status: ST_INSERTED};
                state_next = S_RESP;
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            nfb_reg     <= '0;
            cvalid_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            nfb_reg     <= nfb_next;
            m_valid_reg <= m_valid_next;
            if (cache_we) begin
                cvalid_reg[item_reg.home] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        bucket_reg <= bucket_next;
        idx_reg    <= idx_next;
        cslot_reg  <= cslot_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[key_wa] <= key_wd;
        end
        key_rdata <= key_mem[key_ra];
    end

    // the hit slot is the slot under the walk pointer
    always_ff @(posedge aclk) begin
        if (cache_we) begin
            cache_mem[item_reg.home] <= cur_slot;
        end
        cache_rdata <= cache_mem[cache_ra];
    end

    assign clearing = (state_reg == S_CLEAR);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    `CBHM_NEVER(a_nfb_bound, aclk, aresetn, nfb_reg > NFB_W'(POOL_BUCKETS))
    `CBHM_ASSERT(a_fail_slot0, aclk, aresetn,
        (m_valid && (m_data.status == ST_INVALID || m_data.status == ST_EXHAUSTED))
        |-> (m_data.slot_index == 11'd0))
    `CBHM_NEVER(a_no_out_clear, aclk, aresetn, clearing && m_valid)
    `CBHM_ASSERT(a_alloc_step, aclk, aresetn,
        (state_reg == S_ALLOC) |-> (nfb_reg == $past(nfb_reg) + 1'b1))

endmodule

// ===== rtl/core/chained_bucket_hash_map.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chained_bucket_hash_map
// key to slot map with chained overflow buckets and per-home hit cache
// ---------------------------------------------------------------------------
// channel | dir | handshake          | payload
// s_      | in  | s_valid / s_ready  | s_data  (action, key)
// m_      | out | m_valid / m_ready  | m_data  (slot_index, status)
//
// reset clears the key store in a pass over all 2048 slots, one slot per cycle;
//   s_ready stays low until the pass is done
// a cache hit runs S_IDLE, S_CACHE, S_CACHE_CHK, S_RESP; a walk reads one slot per S_SCAN
//   step, plus an S_ALLOC step for an overflow allocation; the single key read port sets this
// the front queue holds two request beats while the engine or m_ready stalls
// a finished result waits in the output register without holding up the front
module chained_bucket_hash_map (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cbhm_pkg::cbhm_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cbhm_pkg::cbhm_out_t m_data
);
    import cbhm_pkg::*;

    // queue between front and engine
    logic       q_valid;
    logic       q_pop;
    cbhm_item_t q_item;
    logic       clearing;

    // front: classify reserved keys, compute home bucket, queue beats
    cbhm_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .clearing (clearing),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // engine: cache check, chain walk, insert, tombstone, result register
    cbhm_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .clearing (clearing),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
